// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_SYNC(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/u8u16_pkg.sv -----
// Types and constants shared by the UTF-8 to UTF-16 decoder modules.
package u8u16_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned UNIT_W   = 16;
    localparam int unsigned SIZE_W   = 18;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned PART_W   = 11;
    localparam int unsigned PEND_W   = 2;
    localparam int unsigned TDATA_W  = 40;

    localparam logic [COUNT_W-1:0] MAX_UNITS = 16'd65535;

    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
    localparam logic [BYTE_W-1:0] ASCII_MAX  = 8'h7F;

    localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;

    typedef struct packed {
        logic              en;
        logic [BYTE_W-1:0] data_byte;
    } step_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size_bytes;
        logic              is_end;
        logic [UNIT_W-1:0] code_unit;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } out_item_t;

endpackage

// ----- rtl/core/u8u16_in_reg.sv -----
// Input register stage holding one accepted byte.
module u8u16_in_reg
    import u8u16_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    input  logic              out_free,
    output step_t             step
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    assign s_tready = !valid_reg || out_free;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            byte_reg <= s_tdata;
        end
    end

    assign step.en        = valid_reg && out_free;
    assign step.data_byte = byte_reg;

endmodule

// ----- rtl/core/u8u16_decode.sv -----
// Per-byte decode logic and sequence state.
module u8u16_decode
    import u8u16_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  step_t     step,
    output out_item_t item
);

    logic [PEND_W-1:0]  pending_reg;
    logic [PEND_W-1:0]  pending_next;
    logic [PART_W-1:0]  partial_reg;
    logic [PART_W-1:0]  partial_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    logic [BYTE_W-1:0]  b;
    logic [PART_W+5:0]  acc_full;
    logic [UNIT_W-1:0]  acc;
    logic [COUNT_W:0]   count_p1;
    logic [COUNT_W-1:0] count_inc;

    assign b         = step.data_byte;
    assign acc_full  = {partial_reg, b[5:0]};
    assign acc       = acc_full[UNIT_W-1:0];
    assign count_p1  = {1'b0, count_reg} + {{COUNT_W{1'b0}}, 1'b1};
    assign count_inc = (count_reg == MAX_UNITS) ? count_reg : count_p1[COUNT_W-1:0];

    always_comb begin
        pending_next       = pending_reg;
        partial_next       = partial_reg;
        count_next         = count_reg;
        item.valid         = 1'b0;
        item.res.code_unit = '0;
        item.res.is_end    = 1'b0;
        item.res.size_bytes = '0;
        if (b == '0) begin
            item.valid          = 1'b1;
            item.res.is_end     = 1'b1;
            item.res.size_bytes = {count_p1, 1'b0};
            pending_next        = PEND_NONE;
            partial_next        = '0;
            count_next          = '0;
        end else if (pending_reg != PEND_NONE) begin
            if (pending_reg == PEND_ONE) begin
                item.valid         = 1'b1;
                item.res.code_unit = acc;
                pending_next       = PEND_NONE;
                partial_next       = '0;
                count_next         = count_inc;
            end else begin
                pending_next = PEND_ONE;
                partial_next = acc[PART_W-1:0];
            end
        end else if (b <= ASCII_MAX) begin
            item.valid         = 1'b1;
            item.res.code_unit = {{(UNIT_W-BYTE_W){1'b0}}, b};
            count_next         = count_inc;
        end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            pending_next = PEND_ONE;
            partial_next = {{(PART_W-5){1'b0}}, b[4:0]};
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            pending_next = PEND_TWO;
            partial_next = {{(PART_W-5){1'b0}}, b[4:0]};
        end
        if (!step.en) begin
            item.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= PEND_NONE;
            partial_reg <= '0;
            count_reg   <= '0;
        end else if (step.en) begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
            count_reg   <= count_next;
        end
    end

endmodule

// ----- rtl/core/u8u16_out_reg.sv -----
// Result register driving the output stream.
module u8u16_out_reg
    import u8u16_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  out_item_t          item,
    output logic               out_free,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // code_unit[15:0], size_bytes[33:16], zero[39:34]
    output logic               m_tlast
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (out_free) begin
            valid_next = item.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && item.valid) begin
            res_reg <= item.res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(TDATA_W-SIZE_W-UNIT_W){1'b0}}, res_reg.size_bytes, res_reg.code_unit};
    assign m_tlast  = res_reg.is_end;

endmodule

// ----- rtl/core/utf8_to_utf16_decoder.sv -----
// UTF-8 to UTF-16 decoder, one byte per transfer in, one code unit per transfer out.
// Path: an input byte is held in the input register, decoded, then held in the result register.
// Throughput: one byte per cycle while m_tready does not stall the result register, set by
// the per-byte decode between the input register and the result register.
// Reset: synchronous aresetn clears both stage valids and the sequence state.
module utf8_to_utf16_decoder
    import u8u16_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [BYTE_W-1:0]  s_tdata,   // data_byte[7:0]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // code_unit[15:0], size_bytes[33:16], zero[39:34]
    output logic               m_tlast
);

    step_t     step;
    out_item_t item;
    logic      out_free;

    u8u16_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .out_free (out_free),
        .step     (step)
    );

    u8u16_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item)
    );

    u8u16_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item     (item),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- rtl/core/u8u16_checker.sv -----
// Port-level checker for the decoder and its bind to the top level.
`include "assert_macros.svh"

module u8u16_checker
    import u8u16_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tlast
);

    `ASSERT_SYNC(a_term_unit_zero, aclk, aresetn, (m_tvalid && m_tlast) |-> (m_tdata[15:0] == 16'd0 && m_tdata[16] == 1'b0 && m_tdata[33:16] != 18'd0), "terminator must carry unit 0 and a nonzero even size")
    `ASSERT_SYNC(a_unit_size_zero, aclk, aresetn, (m_tvalid && !m_tlast) |-> (m_tdata[33:16] == 18'd0), "ordinary unit must carry size 0")
    `ASSERT_SYNC(a_pad_zero, aclk, aresetn, m_tvalid |-> (m_tdata[39:34] == 6'd0), "tdata padding must be zero")
    `ASSERT_SYNC(a_hold_stalled, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)), "stalled result must hold")
    `ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_tvalid, "reset must clear the result valid")

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- tb/sv/utf8_to_utf16_decoder_tb.sv -----
// Self-checking stream testbench for the UTF-8 to UTF-16 decoder: byte feed, decode predictor, result check.
module utf8_to_utf16_decoder_tb;
    import u8u16_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RUN_LIMIT    = 800_000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned PHASE_BYTES  = 150;

    typedef enum int unsigned {
        PH_STEADY,
        PH_SEND_GAPS,
        PH_RECV_STALLS,
        PH_BOTH
    } phase_e;

    typedef struct {
        logic [BYTE_W-1:0] data;
        phase_e            phase;
    } feed_item_t;

    logic               aclk;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [BYTE_W-1:0]  s_tdata  = '0;   // data_byte[7:0]
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;         // code_unit[15:0], size_bytes[33:16], zero[39:34]
    logic               m_tlast;

    feed_item_t byte_feed[$];
    result_t    unit_expect_q[$];
    phase_e     cur_phase = PH_STEADY;

    logic [PEND_W-1:0]  pend_cnt = PEND_NONE;
    logic [PART_W-1:0]  part_bits = '0;
    logic [COUNT_W-1:0] unit_cnt = '0;

    int unsigned err_cnt     = 0;
    int unsigned cycle_cnt   = 0;
    int unsigned bytes_sent  = 0;
    int unsigned units_seen  = 0;
    int unsigned strings_end = 0;
    int unsigned max_size    = 0;

    utf8_to_utf16_decoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    function automatic int unsigned send_idle_pct(input phase_e ph);
        case (ph)
            PH_SEND_GAPS: return 45;
            PH_BOTH:      return 31;
            default:      return 0;
        endcase
    endfunction

    function automatic int unsigned recv_stall_pct(input phase_e ph);
        case (ph)
            PH_RECV_STALLS: return 45;
            PH_BOTH:        return 31;
            default:        return 0;
        endcase
    endfunction

    function automatic void bump_unit_cnt();
        if (unit_cnt != MAX_UNITS)
            unit_cnt = unit_cnt + 1'b1;
    endfunction

    // Advance the decode state by one byte; return 1 when a code unit or a terminator result results.
    function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output result_t r);
        logic [PART_W+5:0] acc;
        r = '0;
        if (b == '0) begin
            r.is_end     = 1'b1;
            r.size_bytes = (SIZE_W'(unit_cnt) + SIZE_W'(1)) << 1;
            pend_cnt     = PEND_NONE;
            part_bits    = '0;
            unit_cnt     = '0;
            return 1'b1;
        end
        if (pend_cnt != PEND_NONE) begin
            acc      = {part_bits, b[5:0]};
            pend_cnt = pend_cnt - 1'b1;
            if (pend_cnt == PEND_NONE) begin
                part_bits   = '0;
                r.code_unit = acc[UNIT_W-1:0];
                bump_unit_cnt();
                return 1'b1;
            end
            part_bits = acc[PART_W-1:0];
            return 1'b0;
        end
        if (b <= ASCII_MAX) begin
            r.code_unit = UNIT_W'(b);
            bump_unit_cnt();
            return 1'b1;
        end
        if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            part_bits = PART_W'(b[4:0]);
            pend_cnt  = PEND_ONE;
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            part_bits = PART_W'(b[4:0]);
            pend_cnt  = PEND_TWO;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input logic [TDATA_W-1:0] got,
                                   input logic [TDATA_W-1:0] want);
        $display("MISMATCH %s at cycle %0d: got 0x%0h, expected 0x%0h",
                 what, cycle_cnt, got, want);
        err_cnt++;
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b, input phase_e ph);
        feed_item_t it;
        it.data  = b;
        it.phase = ph;
        byte_feed.push_back(it);
    endtask

    function automatic logic [BYTE_W-1:0] rand_cont();
        return 8'h80 | 8'($urandom_range(63));
    endfunction

    // Mostly well-formed sequences, with stray bytes, bad continuations and cut-off leads.
    task automatic push_random_string(input phase_e ph);
        int unsigned pieces;
        int unsigned pick;
        pieces = $urandom_range(16, 1);
        for (int unsigned i = 0; i < pieces; i++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                push_byte(8'($urandom_range(127, 1)), ph);
            end else if (pick < 60) begin
                push_byte(8'hC0 | 8'($urandom_range(31)), ph);
                push_byte(($urandom_range(9) == 0) ? 8'($urandom_range(255, 1)) : rand_cont(), ph);
            end else if (pick < 80) begin
                push_byte(8'hE0 | 8'($urandom_range(15)), ph);
                push_byte(rand_cont(), ph);
                push_byte(($urandom_range(9) == 0) ? 8'($urandom_range(255, 1)) : rand_cont(), ph);
            end else if (pick < 88) begin
                push_byte(($urandom_range(1) == 0) ? 8'($urandom_range(8'hBF, 8'h80))
                                                   : 8'($urandom_range(8'hFF, 8'hF0)), ph);
            end else if (pick < 94) begin
                push_byte(($urandom_range(1) == 0) ? (8'hC0 | 8'($urandom_range(31)))
                                                   : (8'hE0 | 8'($urandom_range(15))), ph);
                if ($urandom_range(1) == 0)
                    push_byte(rand_cont(), ph);
            end else begin
                push_byte(8'($urandom_range(255, 1)), ph);
            end
        end
        push_byte(8'h00, ph);
    endtask

    always @(posedge aclk) begin : drive
        feed_item_t nxt;
        result_t    r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                bytes_sent++;
                if (decode_byte(s_tdata, r))
                    unit_expect_q.push_back(r);
            end
            if (!s_tvalid || s_tready) begin
                if (byte_feed.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct(byte_feed[0].phase)) begin
                    nxt = byte_feed.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= nxt.data;
                    cur_phase <= nxt.phase;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (unit_expect_q.size() == 0) begin
                    report_mismatch("unexpected transfer", m_tdata, '0);
                end else begin
                    want = unit_expect_q.pop_front();
                    units_seen++;
                    if (m_tdata[15:0] !== want.code_unit)
                        report_mismatch("code_unit", m_tdata[15:0], want.code_unit);
                    if (m_tlast !== want.is_end)
                        report_mismatch("is_end", m_tlast, want.is_end);
                    if (m_tdata[33:16] !== want.size_bytes)
                        report_mismatch("size_bytes", m_tdata[33:16], want.size_bytes);
                    if (want.is_end) begin
                        strings_end++;
                        if (want.size_bytes > max_size)
                            max_size = want.size_bytes;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct(cur_phase));
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= RUN_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int unsigned start_len;

        push_byte(8'h00, PH_STEADY);
        push_byte(8'h01, PH_STEADY);
        push_byte(8'h7F, PH_STEADY);
        push_byte(8'hC2, PH_STEADY);
        push_byte(8'h80, PH_STEADY);
        push_byte(8'hDF, PH_STEADY);
        push_byte(8'hBF, PH_STEADY);
        push_byte(8'hE0, PH_STEADY);
        push_byte(8'h80, PH_STEADY);
        push_byte(8'h80, PH_STEADY);
        push_byte(8'hEF, PH_STEADY);
        push_byte(8'hBF, PH_STEADY);
        push_byte(8'hBF, PH_STEADY);
        push_byte(8'hC3, PH_STEADY);
        push_byte(8'h41, PH_STEADY);
        push_byte(8'h80, PH_STEADY);
        push_byte(8'hF0, PH_STEADY);
        push_byte(8'hFF, PH_STEADY);
        push_byte(8'hE4, PH_STEADY);
        push_byte(8'hFF, PH_STEADY);
        push_byte(8'h00, PH_STEADY);
        push_byte(8'hE4, PH_STEADY);
        push_byte(8'hB8, PH_STEADY);
        push_byte(8'h00, PH_STEADY);

        for (int p = PH_STEADY; p <= PH_BOTH; p++) begin
            start_len = byte_feed.size();
            while (byte_feed.size() - start_len < PHASE_BYTES)
                push_random_string(phase_e'(p));
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (byte_feed.size() != 0 || s_tvalid)
            @(negedge aclk);
        while (unit_expect_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes over %0d strings; checked %0d results, largest size %0d bytes",
                 bytes_sent, strings_end, units_seen, max_size);
        $display("Phases: steady flow, sender gaps, receiver stalls, and both at once");
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/u8u16_pkg.sv
rtl/core/u8u16_in_reg.sv
rtl/core/u8u16_decode.sv
rtl/core/u8u16_out_reg.sv
rtl/core/utf8_to_utf16_decoder.sv
rtl/core/u8u16_checker.sv
tb/sv/utf8_to_utf16_decoder_tb.sv
